// ===== sv/frd_pkg.sv =====
// Package for the frequency record decoder.
// Holds the word types, phase codes, error codes and the canonical-form check.
// No dependencies.
package frd_pkg;

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_END  = 1'b1;

	localparam logic [2:0] ERR_NONE  = 3'd0;
	localparam logic [2:0] ERR_TRUNC = 3'd1;
	localparam logic [2:0] ERR_TABLE = 3'd2;
	localparam logic [2:0] ERR_MODE  = 3'd3;
	localparam logic [2:0] ERR_CANON = 3'd4;

	localparam logic [15:0] TOTAL_RESET = 16'd4096;

	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_MODE  = 3'd0,
		PH_COUNT = 3'd1,
		PH_SYM   = 3'd2,
		PH_LOW   = 3'd3,
		PH_HIGH  = 3'd4
	} phase_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
		logic [8:0] record_alphabet;
	} req_word_t;

	typedef struct packed {
		logic [7:0]  symbol;
		logic [15:0] frequency;
		logic        freq_valid;
		logic [2:0]  error_code;
		logic        record_done;
		logic        last;
	} rsp_word_t;

	typedef struct packed {
		phase_t      phase;
		logic        sparse;
		logic [7:0]  low_byte;
		logic [16:0] running_sum;
		logic [8:0]  nonzero_seen;
		logic [8:0]  symbol_pos;
		logic [8:0]  entries_target;
		logic [7:0]  previous_symbol;
		logic        prev_seen;
	} rec_state_t;

	typedef struct packed {
		logic [1:0] count;
		rsp_word_t  first;
		rsp_word_t  second;
	} step_result_t;

	// True when a record with n nonzero entries belongs in sparse form.
	function automatic logic sparse_ok(input logic [8:0] alphabet, input logic [8:0] n);
		logic [10:0] lhs;
		logic [10:0] rhs;
		lhs = {2'b00, n} + {1'b0, n, 1'b0};
		rhs = {1'b0, alphabet, 1'b0} - 11'd1;
		return lhs < rhs;
	endfunction

endpackage

// ===== sv/frd_core.sv =====
// Record decoding state machine of the frequency record decoder.
// Consumes one request word per step and produces up to two result words.
// Depends on frd_pkg.
module frd_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  frd_pkg::req_word_t    item,
	input  logic [15:0]           total_freq,
	output frd_pkg::step_result_t results
);
	import frd_pkg::*;

	rec_state_t rec_q;
	rec_state_t rec_n;
	logic       err_hold_q;
	logic       hold_n;

	logic [7:0]  b;
	logic [8:0]  alpha;
	logic        alpha_bad;
	logic [15:0] freq;
	logic [16:0] sum_add;
	logic [8:0]  nz_inc;
	logic [15:0] rem_d;
	logic [8:0]  nz_fin;
	logic [15:0] rem_s;
	logic [8:0]  target_new;
	logic        sym_bad;
	logic        sym_more;
	logic        dense_more;

	assign b          = item.data_byte;
	assign alpha      = item.record_alphabet;
	assign alpha_bad  = (alpha < 9'd2) || (alpha > 9'd256);
	assign freq       = {b, rec_q.low_byte};
	assign sum_add    = rec_q.running_sum + {1'b0, freq};
	assign nz_inc     = rec_q.nonzero_seen + {8'd0, (freq != 16'd0)};
	assign rem_d      = total_freq - sum_add[15:0];
	assign nz_fin     = nz_inc + {8'd0, (rem_d != 16'd0)};
	assign rem_s      = total_freq - rec_q.running_sum[15:0];
	assign target_new = {1'b0, b} + 9'd1;
	assign sym_bad    = ({1'b0, b} >= alpha) ||
		(rec_q.prev_seen && (b <= rec_q.previous_symbol));
	assign sym_more   = ({1'b0, rec_q.symbol_pos} + 10'd1) < {1'b0, rec_q.entries_target};
	assign dense_more = ({1'b0, rec_q.symbol_pos} + 10'd2) < {1'b0, alpha};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q      <= '0;
			err_hold_q <= 1'b0;
		end else if (step) begin
			rec_q      <= rec_n;
			err_hold_q <= hold_n;
		end
	end

	always_comb begin
		rsp_word_t  r0;
		rsp_word_t  r1;
		logic [1:0] n;
		logic       fail_now;
		logic [2:0] fail_code;
		logic       canon_err;
		rec_n     = rec_q;
		hold_n    = err_hold_q;
		r0        = '0;
		r1        = '0;
		n         = 2'd0;
		fail_now  = 1'b0;
		fail_code = ERR_NONE;
		canon_err = 1'b0;
		if (step) begin
			if (item.req_type == REQ_END) begin
				if (!err_hold_q && rec_q.phase != PH_MODE) begin
					r0.error_code  = ERR_TRUNC;
					r0.record_done = 1'b1;
					n = 2'd1;
				end
				rec_n  = '0;
				hold_n = 1'b0;
			end else if (!err_hold_q) begin
				if (alpha_bad) begin
					fail_now  = 1'b1;
					fail_code = ERR_TABLE;
				end else begin
					case (rec_q.phase)
						PH_MODE: begin
							rec_n = '0;
							if (b == 8'd0) begin
								rec_n.phase = PH_LOW;
							end else if (b == 8'd1) begin
								rec_n.sparse = 1'b1;
								rec_n.phase  = PH_COUNT;
							end else begin
								fail_now  = 1'b1;
								fail_code = ERR_MODE;
							end
						end
						PH_COUNT: begin
							if (target_new > alpha) begin
								fail_now  = 1'b1;
								fail_code = ERR_TABLE;
							end else begin
								rec_n.entries_target = target_new;
								rec_n.phase          = PH_SYM;
							end
						end
						PH_SYM: begin
							if (sym_bad) begin
								fail_now  = 1'b1;
								fail_code = ERR_TABLE;
							end else if (sym_more) begin
								rec_n.previous_symbol = b;
								rec_n.prev_seen       = 1'b1;
								rec_n.phase           = PH_LOW;
							end else begin
								canon_err      = !sparse_ok(alpha, rec_q.entries_target);
								r0.symbol      = b;
								r0.frequency   = rem_s;
								r0.freq_valid  = 1'b1;
								r0.error_code  = canon_err ? ERR_CANON : ERR_NONE;
								r0.record_done = 1'b1;
								n      = 2'd1;
								hold_n = canon_err;
								rec_n  = '0;
							end
						end
						PH_LOW: begin
							rec_n.low_byte = b;
							rec_n.phase    = PH_HIGH;
						end
						PH_HIGH: begin
							if (rec_q.sparse) begin
								if (freq == 16'd0 || sum_add >= {1'b0, total_freq}) begin
									fail_now  = 1'b1;
									fail_code = ERR_TABLE;
								end else begin
									r0.symbol         = rec_q.previous_symbol;
									r0.frequency      = freq;
									r0.freq_valid     = 1'b1;
									n                 = 2'd1;
									rec_n.running_sum = sum_add;
									rec_n.symbol_pos  = rec_q.symbol_pos + 9'd1;
									rec_n.phase       = PH_SYM;
								end
							end else if (sum_add > {1'b0, total_freq}) begin
								fail_now  = 1'b1;
								fail_code = ERR_TABLE;
							end else begin
								r0.symbol     = rec_q.symbol_pos[7:0];
								r0.frequency  = freq;
								r0.freq_valid = 1'b1;
								if (dense_more) begin
									n                  = 2'd1;
									rec_n.running_sum  = sum_add;
									rec_n.nonzero_seen = nz_inc;
									rec_n.symbol_pos   = rec_q.symbol_pos + 9'd1;
									rec_n.phase        = PH_LOW;
								end else begin
									canon_err      = sparse_ok(alpha, nz_fin);
									r1.symbol      = alpha[7:0] - 8'd1;
									r1.frequency   = rem_d;
									r1.freq_valid  = 1'b1;
									r1.error_code  = canon_err ? ERR_CANON : ERR_NONE;
									r1.record_done = 1'b1;
									n      = 2'd2;
									hold_n = canon_err;
									rec_n  = '0;
								end
							end
						end
						default: begin
							fail_now  = 1'b1;
							fail_code = ERR_TABLE;
						end
					endcase
				end
			end
			if (fail_now) begin
				r0             = '0;
				r0.error_code  = fail_code;
				r0.record_done = 1'b1;
				n      = 2'd1;
				hold_n = 1'b1;
				rec_n  = '0;
			end
		end
		r0.last        = (n == 2'd1);
		r1.last        = (n == 2'd2);
		results.count  = n;
		results.first  = r0;
		results.second = r1;
	end

`ifndef SYNTHESIS
	a_pair_closes: assert property (@(posedge clk) disable iff (!arst_n)
		results.count == 2'd2 |=> rec_q.phase == PH_MODE)
		else $error("Two results did not close the record.");
	a_hold_silent: assert property (@(posedge clk) disable iff (!arst_n)
		step && err_hold_q && item.req_type == REQ_BYTE |-> results.count == 2'd0)
		else $error("Result produced while an error is held.");
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.req_type == REQ_END |=> rec_q.phase == PH_MODE && !err_hold_q)
		else $error("End word did not clear the record state.");
`endif

endmodule

// ===== sv/frd_out_fifo.sv =====
// Result queue of the frequency record decoder.
// Takes up to two result words per cycle and delivers one per handshake.
// Depends on frd_pkg.
module frd_out_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  frd_pkg::step_result_t push,
	output logic                  room2,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output frd_pkg::rsp_word_t    rsp_word
);
	import frd_pkg::*;

	rsp_word_t             mem_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]  wr_ptr_q;
	logic [OUT_PTR_W-1:0]  rd_ptr_q;
	logic [OUT_CNT_W-1:0]  count_q;
	logic                  pop;
	logic [OUT_PTR_W-1:0]  wr_ptr_1;

	assign rsp_valid = count_q != '0;
	assign rsp_word  = mem_q[rd_ptr_q];
	assign pop       = rsp_valid && rsp_ready;
	assign room2     = count_q <= OUT_CNT_W'(OUT_DEPTH - 2);
	assign wr_ptr_1  = wr_ptr_q + OUT_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(pop);
			count_q  <= count_q + OUT_CNT_W'(push.count) - OUT_CNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= OUT_CNT_W'(OUT_DEPTH))
		else $error("Result queue count out of range.");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> room2)
		else $error("Result queue written without room for two words.");
	a_word_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
		else $error("Result word changed while waiting.");
`endif

endmodule

// ===== sv/frequency_record_decoder.sv =====
// Top level of the frequency record decoder.
// Input register, decoding state machine and result queue; uses frd_pkg,
// frd_core and frd_out_fifo.
//
//   channel  handshake             payload
//   req      req_valid/req_ready   req_word (req_type, data_byte, record_alphabet)
//   rsp      rsp_valid/rsp_ready   rsp_word (symbol .. last)
//   cfg      cfg_valid/cfg_ready   cfg_data (total_frequency)
//
// A word can be accepted in every cycle unless the input register waits. A word taken in
// is decoded from the input register, and its results reach rsp through the result queue.
// One word can yield two results, so the input register waits while more than two
// words sit in the four-entry result queue; this happens only while rsp_ready is held low.
// Reset clears all record state and sets total_frequency to 4096.
module frequency_record_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  frd_pkg::req_word_t req_word,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output frd_pkg::rsp_word_t rsp_word,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);
	import frd_pkg::*;

	logic         valid_s1;
	req_word_t    item_s1;
	logic [15:0]  total_q;
	logic         room2;
	logic         advance;
	step_result_t results;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && room2;
	assign req_ready = !valid_s1 || room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			total_q  <= TOTAL_RESET;
		end else begin
			if (req_valid && req_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				total_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req_word;
		end
	end

	frd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.item       (item_s1),
		.total_freq (total_q),
		.results    (results)
	);

	frd_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (results),
		.room2     (room2),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_word  (rsp_word)
	);

endmodule
